### design/lbfh_pkg.sv
// Shared types and constants for the line byte frequency histogram core.
// Holds item structs, controller/datapath command and status structs, state enum.
// No dependencies.
`default_nettype none

package lbfh_pkg;

    localparam int MAX_LINE   = 1023;
    localparam int COUNT_W    = 10;
    localparam int SYMBOLS    = 256;
    localparam int SYM_W      = 8;
    localparam int FREQ_W     = 17;
    localparam int DIV_STEPS  = 17;
    localparam int STEP_W     = 5;
    localparam int COUNT_CAP  = (1 << COUNT_W) - 1;
    localparam int LIMIT_INT  = (MAX_LINE < COUNT_CAP) ? MAX_LINE : COUNT_CAP;

    localparam logic [COUNT_W-1:0] LINE_LIMIT = COUNT_W'(LIMIT_INT);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(COUNT_CAP);
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(DIV_STEPS - 1);
    localparam logic [SYM_W-1:0]   NEWLINE    = 8'h0A;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [SYM_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] line_length;
        logic [FREQ_W-1:0]  frequency;
        logic               line_closed;
        logic               overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MEM,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic start_line;
        logic set_closed;
        logic set_ovf;
        logic mem_rd;
        logic mem_wr;
        logic div_load;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic is_newline;
        logic closed;
        logic line_full;
        logic total_zero;
        logic div_last;
    } t_status;

endpackage

`default_nettype wire

### design/lbfh_ctrl.sv
// Controller state machine of the histogram core.
// Sequences capture, count update, division and result load; uses lbfh_pkg.
`default_nettype none

module lbfh_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire lbfh_pkg::t_status i_status,
    output lbfh_pkg::t_cmd        o_cmd
);
    import lbfh_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.op == OP_PUSH) begin
                    if (i_status.is_newline || i_status.line_full) n_state = S_DONE;
                    else n_state = S_MEM;
                end else begin
                    if (i_status.total_zero) n_state = S_DONE;
                    else n_state = S_MEM;
                end
            end
            S_MEM: begin
                if (i_status.op == OP_PUSH) n_state = S_DONE;
                else n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                if (i_status.op == OP_PUSH) begin
                    o_cmd.start_line = i_status.closed;
                    if (i_status.is_newline) o_cmd.set_closed = 1'b1;
                    else if (i_status.line_full) o_cmd.set_ovf = 1'b1;
                    else o_cmd.mem_rd = 1'b1;
                end else begin
                    o_cmd.mem_rd = !i_status.total_zero;
                end
            end
            S_MEM: begin
                if (i_status.op == OP_PUSH) o_cmd.mem_wr = 1'b1;
                else o_cmd.div_load = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### design/lbfh_datapath.sv
// Datapath of the histogram core: count memory, generation/valid bits, line state,
// 17-step restoring divider and result register. Uses lbfh_pkg.
`default_nettype none

module lbfh_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lbfh_pkg::t_in_item i_in_item,
    input  wire lbfh_pkg::t_cmd     i_cmd,
    output lbfh_pkg::t_status       o_status,
    output lbfh_pkg::t_out_item     o_out_item
);
    import lbfh_pkg::*;

    logic [COUNT_W:0]   r_mem [SYMBOLS];
    logic [COUNT_W:0]   r_rd;
    logic [SYMBOLS-1:0] r_vld;

    logic               r_op;
    logic [SYM_W-1:0]   r_val;
    logic               r_gen;
    logic [COUNT_W-1:0] r_total;
    logic               r_closed;
    logic               r_ovf;
    logic [COUNT_W:0]   r_rem;
    logic [FREQ_W-1:0]  r_quo;
    logic [STEP_W-1:0]  r_step;
    t_out_item          r_out;

    logic [COUNT_W-1:0] total_eff;
    logic [COUNT_W-1:0] live;
    logic [COUNT_W-1:0] inc;
    logic [COUNT_W-1:0] cnt_c;
    logic               ge;
    logic [COUNT_W:0]   diff;

    assign total_eff = r_closed ? '0 : r_total;
    assign live      = (r_vld[r_val] && (r_rd[COUNT_W] == r_gen)) ? r_rd[COUNT_W-1:0] : '0;
    assign inc       = (live == COUNT_MAX) ? live : live + COUNT_W'(1);
    assign cnt_c     = (live > r_total) ? r_total : live;
    assign ge        = r_rem >= {1'b0, r_total};
    assign diff      = ge ? r_rem - {1'b0, r_total} : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) r_mem[r_val] <= {r_gen, inc};
        if (i_cmd.mem_rd) r_rd <= r_mem[r_val];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_gen    <= 1'b0;
            r_total  <= '0;
            r_closed <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cmd.mem_wr) begin
                r_vld[r_val] <= 1'b1;
                r_total      <= r_total + COUNT_W'(1);
            end
            if (i_cmd.start_line) begin
                r_vld    <= '0;
                r_gen    <= ~r_gen;
                r_total  <= '0;
                r_closed <= 1'b0;
                r_ovf    <= 1'b0;
            end
            if (i_cmd.set_closed) r_closed <= 1'b1;
            if (i_cmd.set_ovf) r_ovf <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_item.opcode;
            r_val <= i_in_item.value;
            r_quo <= '0;
        end
        if (i_cmd.div_load) begin
            r_rem  <= {1'b0, cnt_c};
            r_quo  <= '0;
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= {diff[COUNT_W-1:0], 1'b0};
            r_quo  <= {r_quo[FREQ_W-2:0], ge};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out.line_length <= r_total;
            r_out.frequency   <= (r_op == OP_READ) ? r_quo : '0;
            r_out.line_closed <= r_closed;
            r_out.overflow    <= r_ovf;
        end
    end

    always_comb begin
        o_status.op         = r_op;
        o_status.is_newline = r_val == NEWLINE;
        o_status.closed     = r_closed;
        o_status.line_full  = total_eff >= LINE_LIMIT;
        o_status.total_zero = r_total == '0;
        o_status.div_last   = r_step == LAST_STEP;
    end

    assign o_out_item = r_out;

endmodule

`default_nettype wire

### design/line_byte_frequency_histogram_core.sv
// Sequence: a push passes the execute, memory and done states (a newline or a full line skips memory);
// a read adds the 17-step restoring divider, one quotient bit per cycle, and skips both on an empty line.
// Throughput: one item at a time, accepted only in the idle state; a result
// waiting in the output register does not block the next item's work.
// Reset (synchronous, active low) clears line state, flags and the 256 entry valid bits
// at once; the count memory needs no clearing pass.
`default_nettype none

module line_byte_frequency_histogram_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire lbfh_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output lbfh_pkg::t_out_item      o_out_item
);
    import lbfh_pkg::*;

    t_cmd    cmd;
    t_status status;

    lbfh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lbfh_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

### tb/lbfh_histogram_checker.sv
`timescale 1ns / 1ps
// Checker for line_byte_frequency_histogram_core: watches both item channels, keeps its
// own per-line byte histogram, predicts every result and compares it field by field.
// Depends on lbfh_pkg.
module lbfh_histogram_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire lbfh_pkg::t_in_item  i_in_item,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire lbfh_pkg::t_out_item i_out_item,
    output int                       o_fail_count,
    output int                       o_results_due
);
    import lbfh_pkg::*;

    logic [COUNT_W-1:0] sym_count [SYMBOLS];
    logic               sym_gen   [SYMBOLS];
    logic               line_gen;
    logic [COUNT_W-1:0] line_total;
    logic               line_done;
    logic               line_ovf;
    t_out_item          freq_results_due [$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic void clear_histogram();
        for (int s = 0; s < SYMBOLS; s++) begin
            sym_count[s] = '0;
            sym_gen[s]   = 1'b0;
        end
        line_gen   = 1'b0;
        line_total = '0;
        line_done  = 1'b0;
        line_ovf   = 1'b0;
    endfunction

    function automatic t_out_item histogram_step(t_in_item item);
        t_out_item          res;
        logic [COUNT_W-1:0] live;
        logic [COUNT_W:0]   bumped;
        logic [26:0]        scaled;
        res = '0;
        if (item.opcode == OP_PUSH) begin
            if (line_done) begin
                line_gen = ~line_gen;
                for (int s = 0; s < SYMBOLS; s++) begin
                    sym_count[s] = '0;
                    sym_gen[s]   = ~line_gen;
                end
                line_total = '0;
                line_done  = 1'b0;
                line_ovf   = 1'b0;
            end
            if (item.value == NEWLINE) begin
                line_done = 1'b1;
            end else if (line_total >= LINE_LIMIT) begin
                line_ovf = 1'b1;
            end else begin
                live   = (sym_gen[item.value] == line_gen) ? sym_count[item.value] : '0;
                bumped = {1'b0, live} + 1'b1;
                if (bumped > {1'b0, COUNT_MAX}) begin
                    bumped = {1'b0, COUNT_MAX};
                end
                sym_count[item.value] = bumped[COUNT_W-1:0];
                sym_gen[item.value]   = line_gen;
                line_total            = line_total + 1'b1;
            end
        end else if (line_total != '0) begin
            live = (sym_gen[item.value] == line_gen) ? sym_count[item.value] : '0;
            if (live > line_total) begin
                live = line_total;
            end
            scaled        = {1'b0, live, 16'h0000};
            scaled        = scaled / {17'h00000, line_total};
            res.frequency = scaled[FREQ_W-1:0];
        end
        res.line_length = line_total;
        res.line_closed = line_done;
        res.overflow    = line_ovf;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_out_item want;
        if (!i_rst_n) begin
            clear_histogram();
            freq_results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (freq_results_due.size() == 0) begin
                    report_mismatch("result item with none due", i_out_item.line_length, 0);
                end else begin
                    want = freq_results_due.pop_front();
                    if (i_out_item.line_length !== want.line_length) begin
                        report_mismatch("line_length", i_out_item.line_length,
                                        want.line_length);
                    end
                    if (i_out_item.frequency !== want.frequency) begin
                        report_mismatch("frequency", i_out_item.frequency, want.frequency);
                    end
                    if (i_out_item.line_closed !== want.line_closed) begin
                        report_mismatch("line_closed", i_out_item.line_closed,
                                        want.line_closed);
                    end
                    if (i_out_item.overflow !== want.overflow) begin
                        report_mismatch("overflow", i_out_item.overflow, want.overflow);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                freq_results_due.push_back(histogram_step(i_in_item));
            end
        end
        o_results_due = freq_results_due.size();
    end

endmodule

### tb/line_byte_frequency_histogram_core_test.sv
`timescale 1ns / 1ps
// Top-level test for line_byte_frequency_histogram_core: drives push and read items
// with random gaps, output stalls and a long output hold-off. Depends on lbfh_pkg,
// the core and lbfh_histogram_checker, which predicts and compares.
module line_byte_frequency_histogram_core_test;
    import lbfh_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_ITEMS     = 100;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RUN_LIMIT_CYCLES = 800_000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        results_due;

    int        sent_items = 0;
    int        hold_off = 0;
    logic      no_idle = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    line_byte_frequency_histogram_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    lbfh_histogram_checker histogram_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    task automatic send_item(logic op, logic [SYM_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        in_item.opcode <= op;
        in_item.value  <= val;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_items++;
    endtask

    initial begin : result_sink
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_off != 0) begin
                out_ready <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("line_byte_frequency_histogram_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        int               line_len;
        int               span;
        int               line_no;
        int               random_end;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] sym;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(OP_READ, 8'h41);
        send_item(OP_PUSH, NEWLINE);
        send_item(OP_READ, 8'h00);
        send_item(OP_PUSH, 8'h41);
        send_item(OP_PUSH, 8'h42);
        send_item(OP_PUSH, 8'h41);
        send_item(OP_READ, 8'h41);
        send_item(OP_READ, 8'h42);
        send_item(OP_READ, 8'hFF);
        send_item(OP_READ, NEWLINE);
        send_item(OP_PUSH, NEWLINE);
        send_item(OP_READ, 8'h41);
        send_item(OP_PUSH, 8'h00);
        send_item(OP_READ, 8'h41);
        send_item(OP_READ, 8'h00);
        send_item(OP_PUSH, 8'hFF);
        send_item(OP_PUSH, 8'h00);
        send_item(OP_PUSH, 8'h80);
        send_item(OP_READ, 8'hFF);
        send_item(OP_READ, 8'h7F);
        send_item(OP_PUSH, NEWLINE);
        send_item(OP_PUSH, NEWLINE);
        send_item(OP_READ, 8'hFF);
        send_item(OP_PUSH, 8'hFF);
        send_item(OP_READ, 8'hFF);

        // fill one line past its limit, then close it
        base = 8'($urandom);
        for (int k = 0; k < LIMIT_INT + 6; k++) begin
            if ($urandom_range(0, 99) == 0) begin
                send_item(OP_READ, 8'(base + $urandom_range(0, 3)));
            end
            sym = 8'(base + $urandom_range(0, 3));
            if (sym == NEWLINE) begin
                sym = 8'h00;
            end
            send_item(OP_PUSH, sym);
        end
        send_item(OP_READ, base);
        send_item(OP_READ, 8'(base + 1));
        send_item(OP_PUSH, NEWLINE);
        send_item(OP_READ, base);
        send_item(OP_PUSH, 8'hFF);
        send_item(OP_READ, 8'hFF);

        line_no    = 0;
        random_end = sent_items + RANDOM_ITEMS;
        while (sent_items < random_end) begin
            no_idle = (line_no % 12 == 2);
            if (line_no == 1) begin
                hold_off = HOLD_OFF_CYCLES;
            end
            if (line_no % 25 == 0) begin
                in_valid <= 1'b0;
                while (results_due != 0) @(negedge clk);
            end
            line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 12);
            span     = $urandom_range(0, 7);
            base     = 8'($urandom);
            for (int k = 0; k < line_len; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    sym = ($urandom_range(0, 1) == 0) ? 8'(base + $urandom_range(0, span))
                                                      : 8'($urandom);
                    send_item(OP_READ, sym);
                end
                if ($urandom_range(0, 15) == 0) begin
                    sym = 8'($urandom);
                end else begin
                    sym = 8'(base + $urandom_range(0, span));
                    if (sym == NEWLINE) begin
                        sym = 8'h0B;
                    end
                end
                send_item(OP_PUSH, sym);
            end
            if ($urandom_range(0, 7) != 0) begin
                send_item(OP_PUSH, NEWLINE);
            end
            repeat ($urandom_range(0, 3)) begin
                sym = ($urandom_range(0, 1) == 0) ? 8'(base + $urandom_range(0, span))
                                                  : 8'($urandom);
                send_item(OP_READ, sym);
            end
            line_no++;
        end
        no_idle = 1'b0;

        in_valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("line_byte_frequency_histogram_core: match");
        end else begin
            $display("line_byte_frequency_histogram_core: mismatch");
        end
        $finish;
    end

endmodule
